@@ hw/rtl/ratf_pkg.sv @@
`timescale 1ns / 1ps

package ratf_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0]  NO_TARGET = 8'd255;
   localparam logic [15:0] FAR_AWAY  = 16'd50000;
   localparam logic [6:0]  BRAKE_FULL = 7'd100;
   localparam logic [6:0]  BRAKE_NONE = 7'd0;

   localparam logic [1:0] REPORT_NONE      = 2'd0;
   localparam logic [1:0] REPORT_CANNOT    = 2'd1;
   localparam logic [1:0] REPORT_FOLLOWING = 2'd2;

   localparam logic [1:0] CMD_OBJECT    = 2'd0;
   localparam logic [1:0] CMD_OWN_SPEED = 2'd1;
   localparam logic [1:0] CMD_ENABLE    = 2'd2;
   localparam logic [1:0] CMD_TICK      = 2'd3;

   localparam logic [2:0] CSR_AZIMUTH_WINDOW = 3'd0;
   localparam logic [2:0] CSR_SEARCH_LIMIT   = 3'd1;
   localparam logic [2:0] CSR_KEEPING_GAP    = 3'd2;
   localparam logic [2:0] CSR_SPEED_CEILING  = 3'd3;
   localparam logic [2:0] CSR_GAIN_FAR       = 3'd4;
   localparam logic [2:0] CSR_GAIN_NEAR      = 3'd5;
   localparam logic [2:0] CSR_LOST_TIMEOUT   = 3'd6;

   localparam logic [14:0] AZIMUTH_WINDOW_RESET = 15'd100;
   localparam logic [15:0] SEARCH_LIMIT_RESET   = 16'd1500;
   localparam logic [15:0] KEEPING_GAP_RESET    = 16'd1500;
   localparam logic [15:0] SPEED_CEILING_RESET  = 16'd1500;
   localparam logic [7:0]  GAIN_FAR_RESET       = 8'd128;
   localparam logic [7:0]  GAIN_NEAR_RESET      = 8'd77;
   localparam logic [7:0]  LOST_TIMEOUT_RESET   = 8'd4;

   // floor(y / 5) = (y * DIV5_MAGIC) >> DIV5_SHIFT for y below 2^19
   localparam logic [18:0] DIV5_MAGIC = 19'd419431;
   localparam int          DIV5_SHIFT = 21;

   typedef enum logic [1:0] {
      ITEM_OBJECT,
      ITEM_OWN_SPEED,
      ITEM_ENABLE,
      ITEM_TICK
   } item_kind_type;

   typedef enum logic [1:0] {
      FRAME_OFF,
      FRAME_SEARCH,
      FRAME_TRACK
   } frame_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CMP,
      ST_DIV,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      item_kind_type      kind;
      logic [7:0]         obj_id;
      logic signed [15:0] obj_azimuth;
      logic [15:0]        obj_distance;
      logic signed [15:0] obj_rel_speed;
      logic               obj_is_new;
      logic               frame_last;
      logic signed [15:0] own_speed;
      logic               enable;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

@@ hw/rtl/ratf_front.sv @@
`timescale 1ns / 1ps

module ratf_front
   import ratf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [7:0]         req_obj_id,
   input  logic signed [15:0] req_obj_azimuth,
   input  logic [15:0]        req_obj_distance,
   input  logic signed [15:0] req_obj_rel_speed,
   input  logic               req_obj_is_new,
   input  logic               req_frame_last,
   input  logic signed [15:0] req_own_speed,
   input  logic               req_enable,
   output queue_head_type     head,
   input  logic               head_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type             queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   item_type             decoded;
   logic                 push;
   logic                 pop;

   always_comb begin
      decoded.obj_id        = req_obj_id;
      decoded.obj_azimuth   = req_obj_azimuth;
      decoded.obj_distance  = req_obj_distance;
      decoded.obj_rel_speed = req_obj_rel_speed;
      decoded.obj_is_new    = req_obj_is_new;
      decoded.frame_last    = req_frame_last;
      decoded.own_speed     = req_own_speed;
      decoded.enable        = req_enable;
      case (req_command)
         CMD_OBJECT:    decoded.kind = ITEM_OBJECT;
         CMD_OWN_SPEED: decoded.kind = ITEM_OWN_SPEED;
         CMD_ENABLE:    decoded.kind = ITEM_ENABLE;
         CMD_TICK:      decoded.kind = ITEM_TICK;
         default:       decoded.kind = ITEM_TICK;
      endcase
   end

   assign req_ready = (count_ff < CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign pop       = head_pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

@@ hw/rtl/ratf_back.sv @@
`timescale 1ns / 1ps

module ratf_back
   import ratf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           head_pop,
   input  logic           csr_write,
   input  logic [2:0]     csr_index,
   input  logic [15:0]    csr_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic           rsp_cmd_active,
   output logic [15:0]    rsp_speed_setpoint,
   output logic [6:0]     rsp_brake_request,
   output logic [1:0]     rsp_follow_report,
   output logic [7:0]     rsp_target_id
);

   logic [14:0] azimuth_window_ff;
   logic [15:0] search_limit_ff;
   logic [15:0] keeping_gap_ff;
   logic [15:0] speed_ceiling_ff;
   logic [7:0]  gain_far_ff;
   logic [7:0]  gain_near_ff;
   logic [7:0]  lost_timeout_ff;

   back_state_type state_ff, state_in;
   frame_kind_type frame_kind_ff, frame_kind_in;

   logic        mode_on_ff, mode_on_in;
   logic [7:0]  tracked_id_ff, tracked_id_in;
   logic [15:0] own_speed_ff, own_speed_in;
   logic [15:0] best_distance_ff, best_distance_in;
   logic [7:0]  candidate_id_ff, candidate_id_in;
   logic        frame_started_ff, frame_started_in;
   logic        frame_matched_ff, frame_matched_in;
   logic        frame_lost_ff, frame_lost_in;
   logic [15:0] track_distance_ff, track_distance_in;
   logic [15:0] track_speed_ff, track_speed_in;
   logic        active_ff, active_in;
   logic [15:0] speed_out_ff, speed_out_in;
   logic [6:0]  brake_out_ff, brake_out_in;
   logic [7:0]  ticks_ff, ticks_in;
   logic        ever_seen_ff, ever_seen_in;
   logic [1:0]  report_ff, report_in;

   logic signed [25:0] prod_ff;
   logic signed [24:0] base_ff;
   logic               nonpos_ff;
   logic               sat_ff;
   logic [18:0]        quot_in_ff;

   logic               rsp_valid_ff;
   logic               cmd_active_ff;
   logic [15:0]        speed_setpoint_ff;
   logic [6:0]         brake_request_ff;
   logic [1:0]         follow_report_ff;
   logic [7:0]         target_id_ff;

   logic               take;
   logic               to_compute;
   logic               to_emit;
   logic               out_free;
   logic               emit;

   logic signed [16:0] err;
   logic [7:0]         gain;
   logic signed [16:0] speed_sum;
   logic signed [26:0] t_sum;
   logic signed [30:0] t_scaled;
   logic signed [30:0] ceiling_scaled;
   logic [37:0]        quot_prod;

   logic signed [16:0] az_ext;
   logic signed [16:0] win_ext;
   logic [7:0]         ticks_inc;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign take      = (state_ff == ST_IDLE) && head.valid;
   assign head_pop  = take;
   assign emit      = (state_ff == ST_EMIT) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (to_compute) begin
               state_in = ST_MUL;
            end else if (to_emit) begin
               state_in = ST_EMIT;
            end
         end
         ST_MUL:  state_in = ST_CMP;
         ST_CMP:  state_in = ST_DIV;
         ST_DIV:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign az_ext    = 17'(head.item.obj_azimuth);
   assign win_ext   = $signed({2'b00, azimuth_window_ff});
   assign ticks_inc = (ticks_ff != 8'd255) ? ticks_ff + 8'd1 : ticks_ff;

   assign err       = $signed({1'b0, track_distance_ff}) - $signed({1'b0, keeping_gap_ff});
   assign gain      = err[16] ? gain_near_ff : gain_far_ff;
   assign speed_sum = 17'($signed(own_speed_ff)) + 17'($signed(track_speed_ff));
   assign t_sum     = 27'(base_ff) + 27'(prod_ff);
   assign t_scaled  = (31'(t_sum) <<< 3) + 31'(t_sum);
   assign ceiling_scaled = $signed({5'b0, (26'(speed_ceiling_ff) << 9)
                                          + (26'(speed_ceiling_ff) << 7)});
   assign quot_prod = 38'(quot_in_ff) * 38'(DIV5_MAGIC);

   // item processing and command arithmetic
   always_comb begin
      frame_kind_in     = frame_kind_ff;
      mode_on_in        = mode_on_ff;
      tracked_id_in     = tracked_id_ff;
      own_speed_in      = own_speed_ff;
      best_distance_in  = best_distance_ff;
      candidate_id_in   = candidate_id_ff;
      frame_started_in  = frame_started_ff;
      frame_matched_in  = frame_matched_ff;
      frame_lost_in     = frame_lost_ff;
      track_distance_in = track_distance_ff;
      track_speed_in    = track_speed_ff;
      active_in         = active_ff;
      speed_out_in      = speed_out_ff;
      brake_out_in      = brake_out_ff;
      ticks_in          = ticks_ff;
      ever_seen_in      = ever_seen_ff;
      report_in         = report_ff;
      to_compute        = 1'b0;
      to_emit           = 1'b0;

      if (take) begin
         case (head.item.kind)
            ITEM_OWN_SPEED: begin
               own_speed_in = head.item.own_speed;
            end
            ITEM_ENABLE: begin
               if (mode_on_ff && !head.item.enable) begin
                  active_in    = 1'b0;
                  ever_seen_in = 1'b0;
               end
               mode_on_in = head.item.enable;
            end
            ITEM_TICK: begin
               ticks_in = ticks_inc;
               if (mode_on_ff && (tracked_id_ff != NO_TARGET) && ever_seen_ff &&
                   (ticks_inc >= lost_timeout_ff)) begin
                  mode_on_in    = 1'b0;
                  tracked_id_in = NO_TARGET;
                  ever_seen_in  = 1'b0;
                  active_in     = 1'b0;
               end
            end
            ITEM_OBJECT: begin
               if (!frame_started_ff) begin
                  frame_started_in = 1'b1;
                  frame_matched_in = 1'b0;
                  frame_lost_in    = 1'b0;
                  if (!mode_on_ff) begin
                     frame_kind_in = FRAME_OFF;
                     active_in     = 1'b0;
                  end else if (tracked_id_ff == NO_TARGET) begin
                     frame_kind_in    = FRAME_SEARCH;
                     best_distance_in = FAR_AWAY;
                     candidate_id_in  = NO_TARGET;
                  end else begin
                     frame_kind_in = FRAME_TRACK;
                     active_in     = 1'b0;
                     brake_out_in  = BRAKE_NONE;
                  end
               end

               if (frame_kind_in == FRAME_SEARCH) begin
                  if ((az_ext < win_ext) && (az_ext > -win_ext) &&
                      (head.item.obj_distance <= search_limit_ff) &&
                      (head.item.obj_distance < best_distance_in)) begin
                     best_distance_in = head.item.obj_distance;
                     candidate_id_in  = head.item.obj_id;
                  end
               end else if ((frame_kind_in == FRAME_TRACK) && !frame_matched_in &&
                            !frame_lost_in && (tracked_id_ff != NO_TARGET) &&
                            (head.item.obj_id == tracked_id_ff)) begin
                  if (!head.item.obj_is_new) begin
                     frame_matched_in  = 1'b1;
                     track_distance_in = head.item.obj_distance;
                     track_speed_in    = head.item.obj_rel_speed;
                     ticks_in          = 8'd0;
                     ever_seen_in      = 1'b1;
                     active_in         = 1'b1;
                  end else begin
                     frame_lost_in = 1'b1;
                     mode_on_in    = 1'b0;
                     tracked_id_in = NO_TARGET;
                     ever_seen_in  = 1'b0;
                     active_in     = 1'b0;
                  end
               end

               if (head.item.frame_last) begin
                  frame_started_in = 1'b0;
                  case (frame_kind_in)
                     FRAME_SEARCH: begin
                        tracked_id_in = candidate_id_in;
                        report_in     = REPORT_CANNOT;
                     end
                     FRAME_TRACK: begin
                        if (frame_lost_in) begin
                           report_in = REPORT_CANNOT;
                        end else if (frame_matched_in) begin
                           report_in = REPORT_FOLLOWING;
                        end else begin
                           report_in = REPORT_NONE;
                        end
                     end
                     default: report_in = REPORT_NONE;
                  endcase
                  to_compute = active_in;
                  to_emit    = !active_in;
               end
            end
            default: begin
               own_speed_in = own_speed_ff;
            end
         endcase
      end

      if (state_ff == ST_DIV) begin
         if (nonpos_ff) begin
            speed_out_in = 16'd0;
            brake_out_in = BRAKE_FULL;
         end else if (sat_ff) begin
            speed_out_in = speed_ceiling_ff;
         end else begin
            speed_out_in = quot_prod[DIV5_SHIFT +: 16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         frame_kind_ff     <= FRAME_OFF;
         mode_on_ff        <= 1'b0;
         tracked_id_ff     <= NO_TARGET;
         own_speed_ff      <= 16'd0;
         best_distance_ff  <= FAR_AWAY;
         candidate_id_ff   <= NO_TARGET;
         frame_started_ff  <= 1'b0;
         frame_matched_ff  <= 1'b0;
         frame_lost_ff     <= 1'b0;
         track_distance_ff <= 16'd0;
         track_speed_ff    <= 16'd0;
         active_ff         <= 1'b0;
         speed_out_ff      <= 16'd0;
         brake_out_ff      <= BRAKE_NONE;
         ticks_ff          <= 8'd0;
         ever_seen_ff      <= 1'b0;
         report_ff         <= REPORT_NONE;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         frame_kind_ff     <= frame_kind_in;
         mode_on_ff        <= mode_on_in;
         tracked_id_ff     <= tracked_id_in;
         own_speed_ff      <= own_speed_in;
         best_distance_ff  <= best_distance_in;
         candidate_id_ff   <= candidate_id_in;
         frame_started_ff  <= frame_started_in;
         frame_matched_ff  <= frame_matched_in;
         frame_lost_ff     <= frame_lost_in;
         track_distance_ff <= track_distance_in;
         track_speed_ff    <= track_speed_in;
         active_ff         <= active_in;
         speed_out_ff      <= speed_out_in;
         brake_out_ff      <= brake_out_in;
         ticks_ff          <= ticks_in;
         ever_seen_ff      <= ever_seen_in;
         report_ff         <= report_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         azimuth_window_ff <= AZIMUTH_WINDOW_RESET;
         search_limit_ff   <= SEARCH_LIMIT_RESET;
         keeping_gap_ff    <= KEEPING_GAP_RESET;
         speed_ceiling_ff  <= SPEED_CEILING_RESET;
         gain_far_ff       <= GAIN_FAR_RESET;
         gain_near_ff      <= GAIN_NEAR_RESET;
         lost_timeout_ff   <= LOST_TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_AZIMUTH_WINDOW: azimuth_window_ff <= csr_data[14:0];
            CSR_SEARCH_LIMIT:   search_limit_ff   <= csr_data;
            CSR_KEEPING_GAP:    keeping_gap_ff    <= csr_data;
            CSR_SPEED_CEILING:  speed_ceiling_ff  <= csr_data;
            CSR_GAIN_FAR:       gain_far_ff       <= csr_data[7:0];
            CSR_GAIN_NEAR:      gain_near_ff      <= csr_data[7:0];
            CSR_LOST_TIMEOUT:   lost_timeout_ff   <= csr_data[7:0];
            default:            lost_timeout_ff   <= lost_timeout_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= 26'(err) * $signed({18'b0, gain});
         base_ff <= 25'(speed_sum) <<< 8;
      end
      if (state_ff == ST_CMP) begin
         nonpos_ff  <= (t_sum <= 27'sd0);
         sat_ff     <= (t_scaled > ceiling_scaled);
         quot_in_ff <= t_scaled[25:7];
      end
      if (emit) begin
         cmd_active_ff     <= active_ff;
         speed_setpoint_ff <= speed_out_ff;
         brake_request_ff  <= brake_out_ff;
         follow_report_ff  <= report_ff;
         target_id_ff      <= tracked_id_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cmd_active     = cmd_active_ff;
   assign rsp_speed_setpoint = speed_setpoint_ff;
   assign rsp_brake_request  = brake_request_ff;
   assign rsp_follow_report  = follow_report_ff;
   assign rsp_target_id      = target_id_ff;

endmodule

@@ hw/rtl/radar_acc_target_follow.sv @@
`timescale 1ns / 1ps
// An end-of-frame object gives its response in ST_EMIT, after the multiply, compare and
// divide-by-640 steps when a speed command is computed. Throughput: one request per
// cycle from the queue for all other requests; the back end holds the queue from an
// end-of-frame object until its response is issued, also while the response register is full.
// Reset: synchronous, active high; clears the queue, tracking state and restores registers.

module radar_acc_target_follow
   import ratf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [7:0]         req_obj_id,
   input  logic signed [15:0] req_obj_azimuth,
   input  logic [15:0]        req_obj_distance,
   input  logic signed [15:0] req_obj_rel_speed,
   input  logic               req_obj_is_new,
   input  logic               req_frame_last,
   input  logic signed [15:0] req_own_speed,
   input  logic               req_enable,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_cmd_active,
   output logic [15:0]        rsp_speed_setpoint,
   output logic [6:0]         rsp_brake_request,
   output logic [1:0]         rsp_follow_report,
   output logic [7:0]         rsp_target_id,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   queue_head_type head;
   logic           head_pop;

   assign csr_ready = 1'b1;

   ratf_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_obj_id        (req_obj_id),
      .req_obj_azimuth   (req_obj_azimuth),
      .req_obj_distance  (req_obj_distance),
      .req_obj_rel_speed (req_obj_rel_speed),
      .req_obj_is_new    (req_obj_is_new),
      .req_frame_last    (req_frame_last),
      .req_own_speed     (req_own_speed),
      .req_enable        (req_enable),
      .head              (head),
      .head_pop          (head_pop)
   );

   ratf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .head_pop           (head_pop),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cmd_active     (rsp_cmd_active),
      .rsp_speed_setpoint (rsp_speed_setpoint),
      .rsp_brake_request  (rsp_brake_request),
      .rsp_follow_report  (rsp_follow_report),
      .rsp_target_id      (rsp_target_id)
   );

endmodule
